[src/super_bin_trace_select_unit_macros.svh]
`ifndef SUPER_BIN_TRACE_SELECT_UNIT_MACROS_SVH
`define SUPER_BIN_TRACE_SELECT_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SBTS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SBTS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sbts_pkg.sv]
`default_nettype none

package sbts_pkg;

    localparam int EXT_BITS = 16;
    localparam int AXES     = 2;
    localparam int LANES    = 2 * AXES;
    localparam int IDX_W    = 32;
    localparam int STEP_W   = 31;
    localparam int DVD_W    = 33;
    localparam int REM_W    = 32;
    localparam int WIDE     = 35;
    localparam int ADDR_W   = 5;

    typedef logic [LANES-1:0][DVD_W-1:0]  dvd_vec_t;
    typedef logic [LANES-1:0][REM_W-1:0]  rem_vec_t;
    typedef logic [AXES-1:0]              neg_vec_t;
    typedef logic [AXES-1:0][IDX_W-1:0]   idx_vec_t;
    typedef logic [AXES-1:0][STEP_W-1:0]  step_vec_t;

    typedef struct packed {
        logic en;
        logic vld;
    } pipe_ctrl_t;

    typedef enum logic [2:0] {
        REG_IGI_FIRST   = 3'd0,
        REG_IGI_STEP    = 3'd1,
        REG_IGI_LAST    = 3'd2,
        REG_IGI_EXTENTS = 3'd3,
        REG_IGC_FIRST   = 3'd4,
        REG_IGC_STEP    = 3'd5,
        REG_IGC_LAST    = 3'd6,
        REG_IGC_EXTENTS = 3'd7
    } reg_idx_t;

endpackage

`default_nettype wire

[src/super_bin_trace_select_unit.sv]
`default_nettype none

// Super-bin trace selector. One trace enters per clock on the s_ stream and
// one result leaves per trace on the m_ stream, in order, passing through
// entry stages, the 33-stage bit-per-stage remainder pipeline and the
// range/snap stages. The whole pipeline advances whenever the output register
// is empty or being taken. Per axis the index must lie in
// [first - low, first + step*floor(max(last-first, 0)/step) + high]; its truncated
// remainder to first then decides snap up, snap down or drop. A dropped trace
// shows keep (m_tuser) low with both centres zero. Registers on the APB port
// must only be written while no trace is in flight.
module super_bin_trace_select_unit
    import sbts_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [63:0]       s_tdata,   // trace_igi, trace_igc
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [63:0]            m_tdata,   // center_igi, center_igc
    output logic                   m_tuser,   // keep
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam logic [31:0] HI_MASK = 32'((64'd1 << EXT_BITS) - 64'd1);

    logic [IDX_W-1:0]  first_reg [AXES];
    logic [STEP_W-1:0] step_reg  [AXES];
    logic [IDX_W-1:0]  last_reg  [AXES];
    logic [31:0]       ext_reg   [AXES];

    reg_idx_t ridx;
    logic     wr;

    assign pready = 1'b1;
    assign ridx   = reg_idx_t'(paddr[4:2]);
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < AXES; a++) begin
                first_reg[a] <= IDX_W'(1);
                step_reg[a]  <= STEP_W'(1);
                last_reg[a]  <= IDX_W'(1);
                ext_reg[a]   <= '0;
            end
        end else if (wr) begin
            unique case (ridx)
                REG_IGI_FIRST:   first_reg[0] <= pwdata;
                REG_IGI_STEP:    step_reg[0]  <= pwdata[STEP_W-1:0];
                REG_IGI_LAST:    last_reg[0]  <= pwdata;
                REG_IGI_EXTENTS: ext_reg[0]   <= pwdata;
                REG_IGC_FIRST:   first_reg[1] <= pwdata;
                REG_IGC_STEP:    step_reg[1]  <= pwdata[STEP_W-1:0];
                REG_IGC_LAST:    last_reg[1]  <= pwdata;
                REG_IGC_EXTENTS: ext_reg[1]   <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (ridx)
            REG_IGI_FIRST:   prdata = first_reg[0];
            REG_IGI_STEP:    prdata = 32'(step_reg[0]);
            REG_IGI_LAST:    prdata = last_reg[0];
            REG_IGI_EXTENTS: prdata = ext_reg[0];
            REG_IGC_FIRST:   prdata = first_reg[1];
            REG_IGC_STEP:    prdata = 32'(step_reg[1]);
            REG_IGC_LAST:    prdata = last_reg[1];
            REG_IGC_EXTENTS: prdata = ext_reg[1];
        endcase
    end

    // derived per-axis constants
    step_vec_t               step_eff;
    logic signed [WIDE-1:0]  first_w [AXES];
    logic signed [WIDE-1:0]  lastc_w [AXES];
    logic signed [WIDE-1:0]  step_w  [AXES];
    logic signed [WIDE-1:0]  lo_w    [AXES];
    logic signed [WIDE-1:0]  hi_w    [AXES];

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            step_eff[a] = (step_reg[a] == '0) ? STEP_W'(1) : step_reg[a];
            first_w[a]  = WIDE'($signed(first_reg[a]));
            lastc_w[a]  = ($signed(last_reg[a]) < $signed(first_reg[a]))
                          ? WIDE'($signed(first_reg[a])) : WIDE'($signed(last_reg[a]));
            step_w[a]   = $signed(WIDE'(step_eff[a]));
            lo_w[a]     = $signed(WIDE'(ext_reg[a][EXT_BITS-1:0]));
            hi_w[a]     = $signed(WIDE'((ext_reg[a] >> EXT_BITS) & HI_MASK));
        end
    end

    logic en;
    logic out_vld_reg;
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // stage 1: offsets from first
    logic                   s1_vld_reg;
    logic signed [WIDE-1:0] s1_d_reg  [AXES];
    logic signed [WIDE-1:0] s1_sp_reg [AXES];
    idx_vec_t               s1_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < AXES; a++) begin
                s1_d_reg[a]  <= WIDE'($signed(s_tdata[a*IDX_W +: IDX_W])) - first_w[a];
                s1_sp_reg[a] <= WIDE'($signed(last_reg[a])) - first_w[a];
            end
            s1_idx_reg <= s_tdata;
        end
    end

    // stage 2: magnitudes for the remainder lanes
    logic     s2_vld_reg;
    dvd_vec_t s2_dvd_reg;
    neg_vec_t s2_neg_reg;
    idx_vec_t s2_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < AXES; a++) begin
                s2_neg_reg[a]        <= s1_d_reg[a][WIDE-1];
                s2_dvd_reg[a]        <= s1_d_reg[a][WIDE-1] ? DVD_W'(-s1_d_reg[a])
                                                            : DVD_W'(s1_d_reg[a]);
                s2_dvd_reg[AXES + a] <= s1_sp_reg[a][WIDE-1] ? '0 : DVD_W'(s1_sp_reg[a]);
            end
            s2_idx_reg <= s1_idx_reg;
        end
    end

    pipe_ctrl_t rp_ctrl;
    logic       rp_vld;
    rem_vec_t   rp_rem;
    neg_vec_t   rp_neg;
    idx_vec_t   rp_idx;

    assign rp_ctrl.en  = en;
    assign rp_ctrl.vld = s2_vld_reg;

    sbts_rem_pipe u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rp_ctrl),
        .dvd_in  (s2_dvd_reg),
        .neg_in  (s2_neg_reg),
        .idx_in  (s2_idx_reg),
        .step    (step_eff),
        .vld_out (rp_vld),
        .rem_out (rp_rem),
        .neg_out (rp_neg),
        .idx_out (rp_idx)
    );

    // stage 3: signed remainder and bounds
    logic                   s3_vld_reg;
    logic signed [WIDE-1:0] s3_r_reg    [AXES];
    logic signed [WIDE-1:0] s3_maxv_reg [AXES];
    logic signed [WIDE-1:0] s3_minv_reg [AXES];
    logic signed [WIDE-1:0] s3_idx_reg  [AXES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else if (en) begin
            s3_vld_reg <= rp_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < AXES; a++) begin
                s3_r_reg[a]    <= rp_neg[a] ? -$signed(WIDE'(rp_rem[a]))
                                            : $signed(WIDE'(rp_rem[a]));
                s3_maxv_reg[a] <= lastc_w[a] - $signed(WIDE'(rp_rem[AXES + a])) + hi_w[a];
                s3_minv_reg[a] <= first_w[a] - lo_w[a];
                s3_idx_reg[a]  <= WIDE'($signed(rp_idx[a]));
            end
        end
    end

    // stage 4: range check and snap per axis
    logic              s4_vld_reg;
    logic [AXES-1:0]   s4_keep_reg;
    idx_vec_t          s4_ctr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_vld_reg <= 1'b0;
        end else if (en) begin
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < AXES; a++) begin
                logic inr;
                logic up;
                logic dn;
                logic signed [WIDE-1:0] cup;
                logic signed [WIDE-1:0] cdn;
                inr = (s3_idx_reg[a] >= s3_minv_reg[a]) && (s3_idx_reg[a] <= s3_maxv_reg[a]);
                up  = s3_r_reg[a] > (step_w[a] - lo_w[a] - WIDE'(1));
                dn  = s3_r_reg[a] < (hi_w[a] + WIDE'(1));
                cup = s3_idx_reg[a] + step_w[a] - s3_r_reg[a];
                cdn = s3_idx_reg[a] - s3_r_reg[a];
                s4_keep_reg[a] <= inr && (up || dn);
                s4_ctr_reg[a]  <= up ? cup[IDX_W-1:0] : cdn[IDX_W-1:0];
            end
        end
    end

    // stage 5: output register
    logic [63:0] out_data_reg;
    logic        out_keep_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_keep_reg <= &s4_keep_reg;
            out_data_reg <= (&s4_keep_reg) ? s4_ctr_reg : '0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_keep_reg;

endmodule

`default_nettype wire

[src/sbts_rem_pipe.sv]
`default_nettype none

module sbts_rem_pipe
    import sbts_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire pipe_ctrl_t ctrl,
    input  wire dvd_vec_t   dvd_in,
    input  wire neg_vec_t   neg_in,
    input  wire idx_vec_t   idx_in,
    input  wire step_vec_t  step,
    output logic            vld_out,
    output rem_vec_t        rem_out,
    output neg_vec_t        neg_out,
    output idx_vec_t        idx_out
);

    logic     vld_reg [DVD_W];
    rem_vec_t p_reg   [DVD_W];
    dvd_vec_t dvd_reg [DVD_W];
    neg_vec_t neg_reg [DVD_W];
    idx_vec_t idx_reg [DVD_W];

    // one quotient bit per stage, restoring
    for (genvar s = 0; s < DVD_W; s++) begin : g_stage
        rem_vec_t p_next;
        dvd_vec_t dvd_src;
        rem_vec_t p_src;
        logic     vld_src;
        neg_vec_t neg_src;
        idx_vec_t idx_src;

        if (s == 0) begin : g_first
            assign dvd_src = dvd_in;
            assign p_src   = '0;
            assign vld_src = ctrl.vld;
            assign neg_src = neg_in;
            assign idx_src = idx_in;
        end else begin : g_rest
            assign dvd_src = dvd_reg[s-1];
            assign p_src   = p_reg[s-1];
            assign vld_src = vld_reg[s-1];
            assign neg_src = neg_reg[s-1];
            assign idx_src = idx_reg[s-1];
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [REM_W:0] t;
            logic [REM_W:0] d;
            assign t = {p_src[l], dvd_src[l][DVD_W-1-s]};
            assign d = (REM_W+1)'(step[l % AXES]);
            assign p_next[l] = (t >= d) ? REM_W'(t - d) : REM_W'(t);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (ctrl.en) begin
                vld_reg[s] <= vld_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (ctrl.en) begin
                p_reg[s]   <= p_next;
                dvd_reg[s] <= dvd_src;
                neg_reg[s] <= neg_src;
                idx_reg[s] <= idx_src;
            end
        end
    end

    assign vld_out = vld_reg[DVD_W-1];
    assign rem_out = p_reg[DVD_W-1];
    assign neg_out = neg_reg[DVD_W-1];
    assign idx_out = idx_reg[DVD_W-1];

endmodule

`default_nettype wire

[src/sbts_checker.sv]
`default_nettype none

`include "super_bin_trace_select_unit_macros.svh"

module sbts_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        m_tuser
);

    `SBTS_ASSERT_NOW(a_drop_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == 64'd0, "dropped trace with nonzero center")
    `SBTS_ASSERT_NOW(a_ready_when_free, aclk, aresetn, !m_tvalid || m_tready, s_tready, "input stalled while output free")
    `SBTS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind super_bin_trace_select_unit sbts_checker u_sbts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[sim/super_bin_trace_select_checker.sv]
`timescale 1ns / 1ps

module super_bin_trace_select_checker
    import sbts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          trace_count,
    output int          kept_count,
    output int          pending
);

    typedef struct packed {
        logic        keep;
        logic [31:0] ctr_igi;
        logic [31:0] ctr_igc;
    } bin_result_t;

    logic [31:0] axis_first [2];
    logic [30:0] axis_step [2];
    logic [31:0] axis_last [2];
    logic [31:0] axis_ext [2];
    bin_result_t bin_queue [$];

    assign pending = bin_queue.size();

    function automatic bit snap_to_bin(input int ax, input longint idx, output longint ctr);
        longint lo, hi, first, last, step, span, minv, maxv, r;
        lo = longint'(axis_ext[ax][EXT_BITS-1:0]);
        hi = longint'(axis_ext[ax][2*EXT_BITS-1:EXT_BITS]);
        first = longint'($signed(axis_first[ax]));
        last = longint'($signed(axis_last[ax]));
        step = longint'(axis_step[ax]);
        ctr = 0;
        if (step == 0)
            step = 1;
        span = last - first;
        if (span < 0)
            span = 0;
        minv = first - lo;
        maxv = first + step * (span / step) + hi;
        if (idx < minv || idx > maxv)
            return 0;
        r = (idx - first) % step;
        if (r > step - lo - 1) begin
            ctr = idx + step - r;
            return 1;
        end
        if (r < hi + 1) begin
            ctr = idx - r;
            return 1;
        end
        return 0;
    endfunction

    function automatic bin_result_t predict_bin(input logic [63:0] d);
        bin_result_t res;
        longint ci, cc;
        bit ki, kc;
        ki = snap_to_bin(0, longint'($signed(d[31:0])), ci);
        kc = snap_to_bin(1, longint'($signed(d[63:32])), cc);
        res = '0;
        if (ki && kc) begin
            res.keep = 1'b1;
            res.ctr_igi = ci[31:0];
            res.ctr_igc = cc[31:0];
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        bin_result_t exp_res;
        reg_idx_t ridx;
        if (!aresetn) begin
            for (int k = 0; k < 2; k++) begin
                axis_first[k] <= 32'd1;
                axis_step[k] <= 31'd1;
                axis_last[k] <= 32'd1;
                axis_ext[k] <= 32'd0;
            end
            bin_queue.delete();
            fail_count <= 0;
            trace_count <= 0;
            kept_count <= 0;
        end else begin
            if (psel && penable && pwrite) begin
                ridx = reg_idx_t'(paddr[4:2]);
                case (ridx)
                    REG_IGI_FIRST:   axis_first[0] <= pwdata;
                    REG_IGI_STEP:    axis_step[0] <= pwdata[30:0];
                    REG_IGI_LAST:    axis_last[0] <= pwdata;
                    REG_IGI_EXTENTS: axis_ext[0] <= pwdata;
                    REG_IGC_FIRST:   axis_first[1] <= pwdata;
                    REG_IGC_STEP:    axis_step[1] <= pwdata[30:0];
                    REG_IGC_LAST:    axis_last[1] <= pwdata;
                    REG_IGC_EXTENTS: axis_ext[1] <= pwdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                bin_queue.push_back(predict_bin(s_tdata));
                trace_count <= trace_count + 1;
            end
            if (m_tvalid && m_tready) begin
                if (bin_queue.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result transfer: keep=%0b data=%h",
                                 m_tuser, m_tdata);
                end else begin
                    exp_res = bin_queue.pop_front();
                    if (m_tuser)
                        kept_count <= kept_count + 1;
                    if (m_tuser !== exp_res.keep || m_tdata[31:0] !== exp_res.ctr_igi
                            || m_tdata[63:32] !== exp_res.ctr_igc) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: exp keep=%0b igi=%0d igc=%0d, got keep=%0b igi=%0d igc=%0d",
                                     exp_res.keep, $signed(exp_res.ctr_igi),
                                     $signed(exp_res.ctr_igc), m_tuser,
                                     $signed(m_tdata[31:0]), $signed(m_tdata[63:32]));
                    end
                end
            end
        end
    end

endmodule

[sim/super_bin_trace_select_unit_tb.sv]
`timescale 1ns / 1ps

module super_bin_trace_select_unit_tb;
    import sbts_pkg::*;

    localparam int DRAIN_CYCLES = 60;
    localparam int IDLE_LIMIT = 5000;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [63:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [63:0] m_tdata;
    logic m_tuser;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    int fail_count;
    int trace_count;
    int kept_count;
    int pending;
    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;

    super_bin_trace_select_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    super_bin_trace_select_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .trace_count(trace_count), .kept_count(kept_count),
        .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input reg_idx_t ridx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(ridx) << 2;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_axis(input int ax, input logic [31:0] first, input logic [31:0] step,
                            input logic [31:0] last, input logic [15:0] lo,
                            input logic [15:0] hi);
        write_reg(reg_idx_t'(4 * ax + 0), first);
        write_reg(reg_idx_t'(4 * ax + 1), step);
        write_reg(reg_idx_t'(4 * ax + 2), last);
        write_reg(reg_idx_t'(4 * ax + 3), {hi, lo});
    endtask

    task automatic send_trace(input logic [31:0] igi, input logic [31:0] igc);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {igc, igi};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] near_grid(input int first, input int step, input int n);
        int k;
        k = $urandom_range(n + 1);
        return first + k * step + $signed($urandom_range(2 * step + 4)) - step - 2;
    endfunction

    task automatic random_phase(input int count, input int first_i, input int step_i,
                                input int last_i, input int first_c, input int step_c,
                                input int last_c);
        logic [31:0] igi, igc;
        int ni, nc;
        ni = (last_i - first_i) / step_i;
        nc = (last_c - first_c) / step_c;
        for (int n = 0; n < count; n++) begin
            igi = near_grid(first_i, step_i, ni);
            igc = near_grid(first_c, step_c, nc);
            if ($urandom_range(9) == 0)
                igi = $urandom;
            if ($urandom_range(9) == 0)
                igc = $urandom;
            send_trace(igi, igc);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset grid: only index 1 on both axes survives
        send_trace(32'd1, 32'd1);
        send_trace(32'd0, 32'd1);
        send_trace(32'd2, 32'd1);
        send_trace(32'h8000_0000, 32'h7fff_ffff);
        send_trace(32'hffff_ffff, 32'hffff_ffff);
        wait_drained();

        set_axis(0, 32'd10, 32'd5, 32'd40, 16'd2, 16'd1);
        set_axis(1, 32'd1, 32'd1, 32'd1, 16'd0, 16'd0);
        for (int v = 5; v <= 46; v += 3)
            send_trace(v, 32'd1);
        send_trace(32'd10, 32'd2);
        wait_drained();

        // last below first, extents wider than the step, zero step, extreme bounds
        set_axis(0, 32'd100, 32'd0, 32'd50, 16'hffff, 16'hffff);
        set_axis(1, -32'sd2000000000, 32'd2000000000, 32'd2000000000, 16'd7, 16'd9);
        send_trace(32'd100, -32'sd2000000000);
        send_trace(-32'sd65435, 32'd2000000000);
        send_trace(32'd65635, -32'sd2000000007);
        send_trace(32'd65636, 32'd2000000009);
        send_trace(32'd0, 32'd0);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 27 : 70) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 27 : 70) : 0;
            case (ph)
                0: begin
                    set_axis(0, -32'sd50, 32'd7, 32'd200, 16'd3, 16'd2);
                    set_axis(1, 32'd3, 32'd4, 32'd60, 16'd1, 16'd1);
                    random_phase(110, -50, 7, 200, 3, 4, 60);
                end
                1: begin
                    set_axis(0, 32'd1000, 32'd100, 32'd5000, 16'd40, 16'd59);
                    set_axis(1, -32'sd300, 32'd13, 32'd100, 16'd0, 16'd12);
                    random_phase(110, 1000, 100, 5000, -300, 13, 100);
                end
                2: begin
                    set_axis(0, 32'd0, 32'd65536, 32'd1966080, 16'hfff0, 16'd15);
                    set_axis(1, 32'd5, 32'd3, 32'd5, 16'd1, 16'd1);
                    random_phase(110, 0, 65536, 1966080, 5, 3, 5);
                end
                default: begin
                    set_axis(0, 32'd1, 32'd1, 32'd1000, 16'd0, 16'd0);
                    set_axis(1, 32'd1, 32'd1, 32'd1, 16'd0, 16'd0);
                    random_phase(110, 1, 1, 1000, 1, 1, 1);
                end
            endcase
            wait_drained();
        end

        $display("checked %0d traces (%0d kept) over directed grids and four idling phases",
                 trace_count, kept_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/sbts_pkg.sv
src/sbts_rem_pipe.sv
src/super_bin_trace_select_unit.sv
src/sbts_checker.sv
sim/super_bin_trace_select_checker.sv
sim/super_bin_trace_select_unit_tb.sv
